// File: hdl/udpb_pkg.sv
// Package for the IPv4/UDP header builder: fixed header constants.
// No dependencies.
package udpb_pkg;

	localparam int unsigned AddrW      = 32;
	localparam int unsigned TtlW       = 8;
	localparam int unsigned PortW      = 16;
	localparam int unsigned PlenW      = 11;
	localparam int unsigned HalfW      = 16;
	localparam int unsigned WordW      = 32;
	localparam int unsigned WordsOut   = 7;
	localparam int unsigned WordIdxW   = $clog2(WordsOut);

	localparam logic [PlenW-1:0]    MaxPayload  = PlenW'(1472);
	localparam logic [HalfW-1:0]    IpUdpHdrLen = HalfW'(28);
	localparam logic [HalfW-1:0]    UdpHdrLen   = HalfW'(8);
	localparam logic [TtlW-1:0]     ProtoUdp    = TtlW'(17);
	localparam logic [HalfW-1:0]    VerIhlTos   = 16'h4500;
	localparam logic [WordIdxW-1:0] LastIdx     = WordIdxW'(WordsOut - 1);

endpackage

// File: hdl/udp_ipv4_header_builder.sv
// IPv4 + UDP header builder: pipelined length/checksum datapath and word serializer.
// Depends on udpb_pkg.
// Requests pass stage registers s1, s2, s3; the serializer then shows the words first to last.
// The single 32-bit result port bounds throughput, as each header leaves it as seven words.
// busy rises when the pipeline backs up behind the serializer; up to four transactions in flight.
// Reset clears all valid bits and the serializer; payload registers are not reset.
module udp_ipv4_header_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [udpb_pkg::AddrW-1:0]    source_address,
	input  logic [udpb_pkg::AddrW-1:0]    dest_address,
	input  logic [udpb_pkg::TtlW-1:0]     time_to_live,
	input  logic [udpb_pkg::PortW-1:0]    source_port,
	input  logic [udpb_pkg::PortW-1:0]    dest_port,
	input  logic [udpb_pkg::PlenW-1:0]    payload_length,
	input  logic [udpb_pkg::HalfW-1:0]    ident,
	output logic                          result_valid,
	output logic [udpb_pkg::WordW-1:0]    header_word,
	output logic                          last_word
);
	import udpb_pkg::*;

	typedef struct packed {
		logic [AddrW-1:0] sa;
		logic [AddrW-1:0] da;
		logic [TtlW-1:0]  ttl;
		logic [PortW-1:0] sp;
		logic [PortW-1:0] dp;
		logic [HalfW-1:0] id;
	} hdr_fields_t;

	localparam int unsigned SumW  = HalfW + 2;
	localparam int unsigned TotW  = HalfW + 3;

	logic                v_s1, v_s2, v_s3;
	logic                adv1, adv2, adv3, accept;
	hdr_fields_t         f_s1, f_s2, f_s3;
	logic [PlenW-1:0]    plen_s1;
	logic [HalfW-1:0]    tot_s2, ulen_s2, tot_s3, ulen_s3;
	logic [SumW-1:0]     suma_s3, sumb_s3;
	logic [PlenW-1:0]    plen_sat;
	logic [TotW-1:0]     sum_all;
	logic [HalfW:0]      fold1;
	logic [HalfW-1:0]    fold2, csum;
	logic                ser_ready, load;
	logic                act_q;
	logic [WordIdxW-1:0] cnt_q;
	logic [WordW-1:0]    word_q [WordsOut];

	assign ser_ready = !act_q || (cnt_q == LastIdx);
	assign load      = v_s3 && ser_ready;
	assign adv3      = !v_s3 || load;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign busy      = !adv1;
	assign accept    = start && !busy;

	// stage 2: saturate payload length, form lengths
	assign plen_sat = (plen_s1 > MaxPayload) ? MaxPayload : plen_s1;

	// final fold: ones-complement sum of both partial sums
	assign sum_all = TotW'(suma_s3) + TotW'(sumb_s3);
	assign fold1   = (HalfW+1)'(sum_all[TotW-1:HalfW]) + (HalfW+1)'(sum_all[HalfW-1:0]);
	assign fold2   = fold1[HalfW-1:0] + HalfW'(fold1[HalfW]);
	assign csum    = ~fold2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			act_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (adv1) v_s1 <= accept;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (ser_ready) begin
				act_q <= v_s3;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + WordIdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_s1.sa  <= source_address;
			f_s1.da  <= dest_address;
			f_s1.ttl <= time_to_live;
			f_s1.sp  <= source_port;
			f_s1.dp  <= dest_port;
			f_s1.id  <= ident;
			plen_s1  <= payload_length;
		end
		if (adv2 && v_s1) begin
			f_s2    <= f_s1;
			tot_s2  <= IpUdpHdrLen + HalfW'(plen_sat);
			ulen_s2 <= UdpHdrLen + HalfW'(plen_sat);
		end
		if (adv3 && v_s2) begin
			f_s3    <= f_s2;
			tot_s3  <= tot_s2;
			ulen_s3 <= ulen_s2;
			suma_s3 <= SumW'(VerIhlTos) + SumW'(tot_s2) + SumW'(f_s2.id)
			           + SumW'({f_s2.ttl, ProtoUdp});
			sumb_s3 <= SumW'(f_s2.sa[AddrW-1:HalfW]) + SumW'(f_s2.sa[HalfW-1:0])
			           + SumW'(f_s2.da[AddrW-1:HalfW]) + SumW'(f_s2.da[HalfW-1:0]);
		end
		if (load) begin
			word_q[0] <= {VerIhlTos, tot_s3};
			word_q[1] <= {f_s3.id, HalfW'(0)};
			word_q[2] <= {f_s3.ttl, ProtoUdp, csum};
			word_q[3] <= f_s3.sa;
			word_q[4] <= f_s3.da;
			word_q[5] <= {f_s3.sp, f_s3.dp};
			word_q[6] <= {ulen_s3, HalfW'(0)};
		end
	end

	assign result_valid = act_q;
	assign header_word  = word_q[cnt_q];
	assign last_word    = act_q && (cnt_q == LastIdx);

endmodule

// File: hdl/udp_ipv4_header_builder_chk.sv
// Port-level checker for udp_ipv4_header_builder, bound into every udp_ipv4_header_builder instance.
// Depends on udpb_pkg.
module udp_ipv4_header_builder_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       result_valid,
	input logic                       last_word,
	input logic [udpb_pkg::WordW-1:0] header_word
);
	import udpb_pkg::*;

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |-> result_valid)
		else $error("last_word without result_valid");

	a_no_break: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_word |=> result_valid)
		else $error("header transaction broke off");

	a_seven_words: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |-> $past(result_valid, 6) && !($past(last_word, 1) || $past(last_word, 2)
			|| $past(last_word, 3) || $past(last_word, 4) || $past(last_word, 5)
			|| $past(last_word, 6)))
		else $error("header transaction not seven words");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (!$past(result_valid) || $past(last_word))
			|-> header_word[WordW-1:HalfW] == VerIhlTos)
		else $error("first word lacks version/IHL/TOS");

endmodule

bind udp_ipv4_header_builder udp_ipv4_header_builder_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.last_word    (last_word),
	.header_word  (header_word)
);

// File: verif/tb_udp_ipv4_header_builder.sv
// Testbench for udp_ipv4_header_builder: drives header requests through start/busy and
// checks the seven header words of each against a local header predictor.
// Depends on udpb_pkg and the udp_ipv4_header_builder RTL.
`timescale 1ns / 1ps

module tb_udp_ipv4_header_builder;
	import udpb_pkg::*;

	localparam int CycleLimit = 60000;
	localparam int NumRandom  = 200;
	localparam int DrainWait  = 16;

	typedef struct {
		logic [AddrW-1:0] src_addr;
		logic [AddrW-1:0] dst_addr;
		logic [TtlW-1:0]  ttl;
		logic [PortW-1:0] src_port;
		logic [PortW-1:0] dst_port;
		logic [PlenW-1:0] plen;
		logic [HalfW-1:0] ident;
		int               gap;
	} hdr_req_t;

	typedef struct {
		logic [WordW-1:0] data;
		logic             is_last;
	} hdr_word_t;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             start          = 1'b0;
	logic             busy;
	logic [AddrW-1:0] source_address = '0;
	logic [AddrW-1:0] dest_address   = '0;
	logic [TtlW-1:0]  time_to_live   = '0;
	logic [PortW-1:0] source_port    = '0;
	logic [PortW-1:0] dest_port      = '0;
	logic [PlenW-1:0] payload_length = '0;
	logic [HalfW-1:0] ident          = '0;
	logic             result_valid;
	logic [WordW-1:0] header_word;
	logic             last_word;

	hdr_req_t  pending_reqs[$];
	hdr_word_t words_due[$];
	int        reqs_total = 0;
	int        reqs_sent  = 0;
	int        mismatches = 0;
	int        idle_left  = 0;
	int        cycle_cnt  = 0;

	udp_ipv4_header_builder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.source_address (source_address),
		.dest_address   (dest_address),
		.time_to_live   (time_to_live),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_length (payload_length),
		.ident          (ident),
		.result_valid   (result_valid),
		.header_word    (header_word),
		.last_word      (last_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// expected header words for one transaction
	function automatic void build_header(input hdr_req_t r);
		logic [PlenW-1:0] plen;
		logic [HalfW-1:0] tot_len, udp_len, csum;
		logic [31:0]      acc;
		logic [WordW-1:0] w[WordsOut];
		hdr_word_t        hw;
		plen    = (r.plen > MaxPayload) ? MaxPayload : r.plen;
		tot_len = IpUdpHdrLen + HalfW'(plen);
		udp_len = UdpHdrLen + HalfW'(plen);
		acc = 32'(VerIhlTos) + 32'(tot_len) + 32'(r.ident) + 32'({r.ttl, ProtoUdp})
			+ 32'(r.src_addr[31:16]) + 32'(r.src_addr[15:0])
			+ 32'(r.dst_addr[31:16]) + 32'(r.dst_addr[15:0]);
		acc  = (acc >> 16) + (acc & 32'h0000_ffff);
		acc  = acc + (acc >> 16);
		csum = ~acc[15:0];
		w[0] = {VerIhlTos, tot_len};
		w[1] = {r.ident, 16'h0000};
		w[2] = {r.ttl, ProtoUdp, csum};
		w[3] = r.src_addr;
		w[4] = r.dst_addr;
		w[5] = {r.src_port, r.dst_port};
		w[6] = {udp_len, 16'h0000};
		for (int k = 0; k < WordsOut; k++) begin
			hw.data    = w[k];
			hw.is_last = (k == WordsOut - 1);
			words_due.push_back(hw);
		end
	endfunction

	function automatic void add_req(input logic [AddrW-1:0] sa, input logic [AddrW-1:0] da,
			input logic [TtlW-1:0] ttl, input logic [PortW-1:0] sp,
			input logic [PortW-1:0] dp, input logic [PlenW-1:0] pl,
			input logic [HalfW-1:0] id, input int gap);
		hdr_req_t r;
		r.src_addr = sa;
		r.dst_addr = da;
		r.ttl      = ttl;
		r.src_port = sp;
		r.dst_port = dp;
		r.plen     = pl;
		r.ident    = id;
		r.gap      = gap;
		pending_reqs.push_back(r);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic     fire;
		hdr_req_t r;
		if (!arst_n) begin
			start     <= 1'b0;
			idle_left = 0;
		end else begin
			fire = start && !busy;
			if (fire) begin
				r.src_addr = source_address;
				r.dst_addr = dest_address;
				r.ttl      = time_to_live;
				r.src_port = source_port;
				r.dst_port = dest_port;
				r.plen     = payload_length;
				r.ident    = ident;
				build_header(r);
				reqs_sent++;
				idle_left = (pending_reqs.size() > 0) ? pending_reqs[0].gap : 0;
			end
			if (start && !fire) begin
				// hold until accepted
			end else if (idle_left > 0) begin
				idle_left--;
				start          <= 1'b0;
				source_address <= $urandom;
				dest_address   <= $urandom;
				time_to_live   <= TtlW'($urandom);
				source_port    <= PortW'($urandom);
				dest_port      <= PortW'($urandom);
				payload_length <= PlenW'($urandom);
				ident          <= HalfW'($urandom);
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				start          <= 1'b1;
				source_address <= r.src_addr;
				dest_address   <= r.dst_addr;
				time_to_live   <= r.ttl;
				source_port    <= r.src_port;
				dest_port      <= r.dst_port;
				payload_length <= r.plen;
				ident          <= r.ident;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// header word monitor
	always @(posedge clk) begin
		hdr_word_t hw;
		if (arst_n && result_valid) begin
			if (words_due.size() == 0) begin
				$error("unexpected header word %08h", header_word);
				mismatches++;
			end else begin
				hw = words_due.pop_front();
				if (header_word !== hw.data) begin
					$error("header_word: expected %08h, got %08h", hw.data, header_word);
					mismatches++;
				end
				if (last_word !== hw.is_last) begin
					$error("last_word: expected %0b, got %0b", hw.is_last, last_word);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("tb_udp_ipv4_header_builder: done, errors");
			$finish;
		end
	end

	initial begin
		int               sel;
		int               gap;
		logic [PlenW-1:0] pl;

		add_req('0, '0, '0, '0, '0, '0, '0, 0);
		add_req('1, '1, '1, '1, '1, 11'd2047, '1, 0);
		add_req(32'hc0a8_0001, 32'hc0a8_00c7, 8'd64, 16'd5353, 16'd53, MaxPayload, 16'd31337, 0);
		add_req(32'h0a00_0001, 32'h0a00_0002, 8'd1, 16'd1024, 16'd80, 11'd1473, 16'd31338, 3);
		add_req(32'h7f00_0001, 32'h7f00_0001, 8'd128, 16'd0, 16'hffff, 11'd1471, 16'hffff, 0);
		add_req(32'hffff_0000, 32'h0000_ffff, 8'd255, 16'hffff, 16'd0, 11'd1, 16'd0, 7);
		add_req(32'h8000_0000, 32'h0000_0001, 8'd0, 16'h8000, 16'h0001, 11'd1024, 16'h8000, 1);
		add_req(32'h0000_0001, 32'h8000_0000, 8'h80, 16'h0001, 16'h8000, 11'd1023, 16'h7fff, 0);
		add_req(32'hffff_ffff, 32'hffff_ffff, 8'd255, 16'd0, 16'd0, 11'd0, 16'hffff, 0);
		add_req(32'hbaaf_ffff, 32'h0000_0000, 8'd0, 16'd0, 16'd0, 11'd0, 16'h0000, 2);
		add_req(32'h1234_5678, 32'h9abc_def0, 8'h5a, 16'h1357, 16'h2468, 11'd1500, 16'ha5a5, 0);
		add_req(32'h0000_0000, 32'hffff_ffff, 8'd17, 16'd65535, 16'd65535, 11'd1472, 16'd1, 5);

		for (int i = 0; i < NumRandom; i++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				pl = PlenW'($urandom_range(1473, 2047));
			else if (sel == 1)
				pl = ($urandom_range(0, 1) == 1) ? MaxPayload : '0;
			else
				pl = PlenW'($urandom_range(0, 1472));
			// every third block of forty requests runs without gaps
			gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 7);
			add_req($urandom, $urandom, TtlW'($urandom), PortW'($urandom), PortW'($urandom),
				pl, HalfW'($urandom), gap);
		end
		reqs_total = pending_reqs.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (reqs_sent == reqs_total);
		wait (words_due.size() == 0);
		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0)
			$display("tb_udp_ipv4_header_builder: done, clean");
		else
			$display("tb_udp_ipv4_header_builder: done, errors");
		$finish;
	end

endmodule
